FILE: rtl/wl8_pkg.sv
// Shared types and constants for the window/level luma mapper.
`timescale 1ns / 1ps
package wl8_pkg;

  // Item kinds on the input stream.
  localparam logic KIND_SURVEY  = 1'b0;
  localparam logic KIND_CONVERT = 1'b1;

  // Sample width modes.
  localparam logic [1:0] MODE_8BIT  = 2'd0;
  localparam logic [1:0] MODE_16BIT = 2'd1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIX_SIGNED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USE_WINDOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT  = 3'd7;

  // Window span and division numerator widths.
  localparam int DIFF_W = 42;
  localparam int NUM_W  = 50;

  typedef struct packed {
    logic take;
    logic mul;
    logic sum;
    logic cmp;
    logic prep;
    logic div;
    logic emit;
  } wl8_cmd_t;

  typedef struct packed {
    logic fast;
    logic clamp;
    logic out_free;
  } wl8_sts_t;

endpackage

FILE: rtl/wl8_ctrl.sv
// Sequencer that steps one convert item through the mapping datapath.
`timescale 1ns / 1ps
module wl8_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_kind,
  input  wl8_pkg::wl8_sts_t sts,
  output wl8_pkg::wl8_cmd_t cmd
);
  import wl8_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SUM, ST_CMP, ST_PREP, ST_DIV, ST_DONE
  } state_t;

  state_t     state;
  logic [2:0] cnt;

  always_comb begin
    cmd      = '0;
    cmd.take = (state == ST_IDLE);
    cmd.mul  = (state == ST_MUL);
    cmd.sum  = (state == ST_SUM);
    cmd.cmp  = (state == ST_CMP);
    cmd.prep = (state == ST_PREP);
    cmd.div  = (state == ST_DIV);
    cmd.emit = (state == ST_DONE) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && in_kind == KIND_CONVERT) begin
            state <= sts.fast ? ST_DONE : ST_MUL;
          end
        end
        ST_MUL:  state <= ST_SUM;
        ST_SUM:  state <= ST_CMP;
        ST_CMP:  state <= sts.clamp ? ST_DONE : ST_PREP;
        ST_PREP: begin
          state <= ST_DIV;
          cnt   <= '0;
        end
        ST_DIV: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (sts.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/wl8_dpath.sv
// Datapath: configuration, auto range, rescale, window compare, divider and output register.
`timescale 1ns / 1ps
module wl8_dpath #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  wl8_pkg::wl8_cmd_t                 cmd,
  output wl8_pkg::wl8_sts_t                 sts,
  input  logic                              cfg_we,
  input  logic [wl8_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              in_valid,
  input  logic [1:0]                        in_user,
  input  logic [15:0]                       in_sample,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_luma,
  output logic                              out_error,
  output logic                              out_last
);
  import wl8_pkg::*;

  localparam int RW = SAMPLE_BITS + 1;
  localparam int PW = RW + 32;
  localparam int VW = PW + 2;

  logic [1:0]  mode;
  logic        pix_signed;
  logic        invert;
  logic        use_window;
  logic [31:0] center;
  logic [31:0] width;
  logic [31:0] slope;
  logic [31:0] icpt;

  logic signed [RW-1:0] range_min;
  logic signed [RW-1:0] range_max;
  logic                 range_valid;

  logic [15:0]          smp;
  logic                 last_r;
  logic                 err_r;
  logic                 noinv;
  logic [7:0]           lum;
  logic signed [VW-1:0] l2;
  logic signed [VW-1:0] u2;
  logic signed [PW-1:0] prod;
  logic signed [VW-1:0] rv2;
  logic [DIFF_W-1:0]    w2;
  logic [DIFF_W-1:0]    diff;
  logic [NUM_W-1:0]     num;
  logic [NUM_W-1:0]     dv;

  function automatic logic signed [RW-1:0] raw_value(input logic [15:0] s, input logic sgn);
    logic [SAMPLE_BITS-1:0] v;
    v = s[SAMPLE_BITS-1:0];
    raw_value = {sgn & v[SAMPLE_BITS-1], v};
  endfunction

  logic                 accept;
  logic signed [RW-1:0] in_raw;
  logic signed [RW-1:0] cv_raw;
  logic                 given;
  logic signed [VW-1:0] l2_sel;
  logic signed [VW-1:0] u2_sel;
  logic signed [VW-1:0] c512;
  logic signed [VW-1:0] w256;
  logic signed [VW-1:0] rsum;
  logic                 le_low;
  logic                 ge_high;
  logic [NUM_W:0]       trial;

  assign accept  = cmd.take && in_valid;
  assign in_raw  = raw_value(in_sample, pix_signed);
  assign cv_raw  = raw_value(smp, pix_signed);
  assign given   = use_window && (width != 32'd0);
  assign c512    = {{(VW-41){center[31]}}, center, 9'b0};
  assign w256    = {{(VW-40){1'b0}}, width, 8'b0};
  assign l2_sel  = given ? (c512 - w256) : {{(VW-RW-17){range_min[RW-1]}}, range_min, 17'b0};
  assign u2_sel  = given ? (c512 + w256) : {{(VW-RW-17){range_max[RW-1]}}, range_max, 17'b0};
  assign rsum    = {{(VW-PW){prod[PW-1]}}, prod} + {{(VW-40){icpt[31]}}, icpt, 8'b0};
  assign le_low  = (rv2 <= l2);
  assign ge_high = (rv2 >= u2);
  assign trial   = {1'b0, num} - {1'b0, dv};

  always_comb begin
    sts.out_free = !out_valid || out_ready;
    sts.clamp    = le_low || ge_high;
    sts.fast     = (mode != MODE_16BIT) ||
                   (!given && (!range_valid || range_min == range_max));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_16BIT;
      pix_signed  <= 1'b0;
      invert      <= 1'b0;
      use_window  <= 1'b0;
      center      <= '0;
      width       <= '0;
      slope       <= 32'h0001_0000;
      icpt        <= '0;
      range_min   <= '0;
      range_max   <= '0;
      range_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH_MODE: mode       <= cfg_data[1:0];
          REG_PIX_SIGNED: pix_signed <= cfg_data[0];
          REG_INVERT:     invert     <= cfg_data[0];
          REG_USE_WINDOW: use_window <= cfg_data[0];
          REG_CENTER:     center     <= cfg_data;
          REG_WIDTH:      width      <= cfg_data;
          REG_SLOPE:      slope      <= cfg_data;
          REG_INTERCEPT:  icpt       <= cfg_data;
          default: ;
        endcase
      end
      if (accept && in_user[0] == KIND_SURVEY) begin
        range_valid <= 1'b1;
        if (in_user[1] || !range_valid) begin
          range_min <= in_raw;
          range_max <= in_raw;
        end else begin
          if (in_raw < range_min) range_min <= in_raw;
          if (in_raw > range_max) range_max <= in_raw;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_user[0] == KIND_CONVERT) begin
      smp    <= in_sample;
      last_r <= in_last;
      l2     <= l2_sel;
      u2     <= u2_sel;
      err_r  <= 1'b0;
      noinv  <= 1'b0;
      lum    <= 8'd0;
      if (mode == MODE_8BIT) begin
        lum <= in_sample[7:0];
      end else if (mode == MODE_16BIT) begin
        if (!given && !range_valid) begin
          err_r <= 1'b1;
          noinv <= 1'b1;
        end else if (!given && range_min == range_max) begin
          lum   <= 8'd128;
          noinv <= 1'b1;
        end
      end else begin
        err_r <= 1'b1;
        noinv <= 1'b1;
      end
    end
    if (cmd.mul) begin
      prod <= PW'(cv_raw) * PW'($signed(slope));
      w2   <= DIFF_W'(u2 - l2);
    end
    if (cmd.sum) begin
      rv2 <= {rsum[VW-2:0], 1'b0};
    end
    if (cmd.cmp) begin
      diff <= DIFF_W'(rv2 - l2);
      if (le_low) begin
        lum <= 8'd0;
      end else if (ge_high) begin
        lum <= 8'd255;
      end
    end
    if (cmd.prep) begin
      num <= NUM_W'({diff, 8'b0}) - NUM_W'(diff) + NUM_W'(w2[DIFF_W-1:1]);
      dv  <= NUM_W'({w2, 7'b0});
    end
    if (cmd.div) begin
      if (!trial[NUM_W]) begin
        num <= trial[NUM_W-1:0];
      end
      dv  <= dv >> 1;
      lum <= {lum[6:0], !trial[NUM_W]};
    end
    if (cmd.emit) begin
      out_luma  <= (invert && !noinv) ? ~lum : lum;
      out_error <= err_r;
      out_last  <= last_r;
    end
  end

endmodule

FILE: rtl/window_level_to_8bit_luma.sv
// Top level of the window/level mapper from medical pixels to 8-bit luma.
//
//   Channel    Direction  Payload
//   s_axis     in         tdata: sample; tuser: kind, frame_start; tlast: last_sample
//   m_axis     out        tdata: luma; tuser: error; tlast: last_pixel
//   cfg        in         cfg_index selects the register, cfg_data is written on cfg_we
//
// A survey item is taken in the idle step. A convert item skips to the final step in
// 8-bit mode, for a flat or unsurveyed range and an unsupported depth, passes
// multiply, sum and compare when outside the window, and inside it also prep and
// a restoring divider with one quotient bit per cycle. Reset is synchronous, clears
// the range and resets the registers. The result waits in an output register, so the
// next item is accepted meanwhile; an untaken result holds the sequencer in ST_DONE.
`timescale 1ns / 1ps
module window_level_to_8bit_luma #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [15:0] sample
  input  logic [1:0]                    s_axis_tuser,  // [0] kind, [1] frame_start
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [7:0] luma
  output logic                          m_axis_tuser,  // [0] error
  output logic                          m_axis_tlast,
  input  logic                          cfg_we,
  input  logic [wl8_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import wl8_pkg::*;

  wl8_cmd_t cmd;
  wl8_sts_t sts;

  assign s_axis_tready = cmd.take;

  wl8_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser[0]),
    .sts      (sts),
    .cmd      (cmd)
  );

  wl8_dpath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_user   (s_axis_tuser),
    .in_sample (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_luma  (m_axis_tdata),
    .out_error (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 8'd0))
    else $error("error result carries nonzero luma");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result present right after reset");

  a_survey_silent: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == KIND_SURVEY && !m_axis_tvalid)
    |=> !m_axis_tvalid)
    else $error("survey item produced a result");
`endif

endmodule
